// ===== rtl/core/rcpd_pkg.sv =====
package rcpd_pkg;

	// drive state encoding, shared by applied and target mode
	localparam logic [1:0] MODE_UNINIT = 2'd0;
	localparam logic [1:0] MODE_FWD    = 2'd1;
	localparam logic [1:0] MODE_BWD    = 2'd2;
	localparam logic [1:0] MODE_BRAKE  = 2'd3;

	// item kinds
	localparam logic FUNC_TICK = 1'b0;
	localparam logic FUNC_EDGE = 1'b1;

	// configuration register indexes
	localparam logic [2:0] REG_PULSE_MIN       = 3'd0;
	localparam logic [2:0] REG_PULSE_MID       = 3'd1;
	localparam logic [2:0] REG_PULSE_MAX       = 3'd2;
	localparam logic [2:0] REG_DEAD_BAND       = 3'd3;
	localparam logic [2:0] REG_FAILSAFE_RELOAD = 3'd4;

	// register reset values
	localparam logic [15:0] PULSE_MIN_RST       = 16'd250;
	localparam logic [15:0] PULSE_MID_RST       = 16'd375;
	localparam logic [15:0] PULSE_MAX_RST       = 16'd500;
	localparam logic [15:0] DEAD_BAND_RST       = 16'd10;
	localparam logic [7:0]  FAILSAFE_RELOAD_RST = 8'd50;

	// quotient bits produced by the divider, one per step
	localparam int unsigned DUTY_W = 8;

	typedef struct packed {
		logic        func;
		logic        level;
		logic [15:0] stamp;
	} in_item_t;

	typedef struct packed {
		logic [1:0] drive_mode;
		logic [7:0] duty;
		logic [1:0] wanted_mode;
		logic       pulse_taken;
	} out_item_t;

	// request to the shared divider
	typedef struct packed {
		logic        start;
		logic [15:0] dividend;
		logic [15:0] divisor;
	} div_req_t;

endpackage

// ===== rtl/core/rcpd_div.sv =====
module rcpd_div (
	input  logic                          clk,
	input  logic                          arst_n,
	input  rcpd_pkg::div_req_t            req,
	output logic                          done,
	output logic [rcpd_pkg::DUTY_W-1:0]   quotient
);

	localparam int unsigned CNT_W = $clog2(rcpd_pkg::DUTY_W);

	logic                        busy_q;
	logic                        done_q;
	logic [CNT_W-1:0]            cnt_q;
	logic [15:0]                 rem_q;
	logic [15:0]                 div_q;
	logic [rcpd_pkg::DUTY_W-1:0] quo_q;

	logic [16:0] shifted;
	logic [16:0] diff;
	logic        fits;

	// one restoring step: shift remainder, trial subtract
	assign shifted = {rem_q, 1'b0};
	assign diff    = shifted - {1'b0, div_q};
	assign fits    = (shifted >= {1'b0, div_q});

	// control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == CNT_W'(rcpd_pkg::DUTY_W - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// datapath, a zero divisor yields all ones
	always_ff @(posedge clk) begin
		if (req.start) begin
			rem_q <= req.dividend;
			div_q <= req.divisor;
			quo_q <= '0;
		end else if (busy_q) begin
			rem_q <= fits ? diff[15:0] : shifted[15:0];
			quo_q <= {quo_q[rcpd_pkg::DUTY_W-2:0], fits};
		end
	end

	assign done     = done_q;
	assign quotient = quo_q;

endmodule

// ===== rtl/core/rc_pulse_to_hbridge_drive.sv =====
// RC pulse to H-bridge drive controller.
// Input channel (in_valid / in_stall / in_item): one transfer per millisecond
// tick or RC edge. Output channel (out_valid / out_stall / out_item): exactly
// one result transfer per input item, in order.
// Configuration: cfg_en writes cfg_data into the register at cfg_index
// (0 pulse_min, 1 pulse_mid, 2 pulse_max, 3 dead_band, 4 failsafe_reload);
// other indexes are ignored. Write only while no item is in flight.
// Path: ticks, rising edges and falling edges that need no scaled duty
// pass through ST_EVAL and ST_OUT into the output register; a falling edge
// that needs a scaled duty also waits in ST_DIV for the 8-step shared
// restoring divider. One item is processed at a time; in_stall is high
// from acceptance until its result has been loaded into the output
// register, so no new item is accepted before then.
// The output register holds a finished result while out_stall is high and
// the next item may already be accepted; that item then waits for the
// register to free up before it completes.
// Reset clears the drive state (uninitialised, duty 0), the failsafe count
// to 50 and the registers to their defaults; the output register is empty.
module rc_pulse_to_hbridge_drive (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_en,
	input  logic [2:0]           cfg_index,
	input  logic [15:0]          cfg_data,
	input  logic                 in_valid,
	output logic                 in_stall,
	input  rcpd_pkg::in_item_t   in_item,
	output logic                 out_valid,
	input  logic                 out_stall,
	output rcpd_pkg::out_item_t  out_item
);

	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_EVAL = 2'd1;
	localparam logic [1:0] ST_DIV  = 2'd2;
	localparam logic [1:0] ST_OUT  = 2'd3;

	logic [1:0] state_q;

	// configuration
	logic [15:0] pulse_min_q;
	logic [15:0] pulse_mid_q;
	logic [15:0] pulse_max_q;
	logic [15:0] dead_band_q;
	logic [7:0]  failsafe_reload_q;

	// controller state
	logic [1:0]  mode_now_q;
	logic [1:0]  mode_goal_q;
	logic [7:0]  duty_goal_q;
	logic [7:0]  duty_now_q;
	logic [15:0] rise_stamp_q;
	logic [7:0]  failsafe_left_q;

	// current item
	logic        func_q;
	logic        level_q;
	logic [15:0] stamp_q;
	logic [15:0] width_q;
	logic        taken_q;
	logic [1:0]  pend_mode_q;

	// output register
	logic                out_valid_q;
	rcpd_pkg::out_item_t out_item_q;

	logic                        in_fire;
	logic                        out_free;
	rcpd_pkg::div_req_t          div_req;
	logic                        div_done;
	logic [rcpd_pkg::DUTY_W-1:0] div_quo;

	// window classification
	logic [16:0] upper_lim;
	logic [15:0] lower_lim;
	logic        in_window;
	logic        go_fwd;
	logic        go_bwd;

	// drive step
	logic [1:0] mode_next;
	logic [7:0] duty_next;

	assign in_fire  = in_valid && !in_stall;
	assign in_stall = (state_q != ST_IDLE);
	assign out_free = !out_valid_q || !out_stall;

	assign upper_lim = {1'b0, pulse_mid_q} + {1'b0, dead_band_q};
	assign lower_lim = pulse_mid_q - dead_band_q;
	assign in_window = (width_q > pulse_min_q) && (width_q < pulse_max_q);
	assign go_fwd    = ({1'b0, width_q} > upper_lim);
	assign go_bwd    = (pulse_mid_q >= dead_band_q) && (width_q < lower_lim);

	// divider request: distance to neutral over half span
	always_comb begin
		div_req.start    = (state_q == ST_EVAL) && func_q == rcpd_pkg::FUNC_EDGE && !level_q
			&& in_window && (go_fwd || go_bwd);
		div_req.dividend = go_fwd ? (width_q - pulse_mid_q) : (pulse_mid_q - width_q);
		div_req.divisor  = go_fwd ? (pulse_max_q - pulse_mid_q) : (pulse_mid_q - pulse_min_q);
	end

	rcpd_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.req      (div_req),
		.done     (div_done),
		.quotient (div_quo)
	);

	// one step toward the target, braking before any change of direction
	always_comb begin
		mode_next = mode_now_q;
		duty_next = duty_now_q;
		if (mode_now_q != mode_goal_q) begin
			if ((mode_goal_q == rcpd_pkg::MODE_FWD || mode_goal_q == rcpd_pkg::MODE_BWD)
				&& mode_now_q == rcpd_pkg::MODE_BRAKE) begin
				duty_next = '0;
				mode_next = mode_goal_q;
			end else begin
				mode_next = rcpd_pkg::MODE_BRAKE;
			end
		end else begin
			duty_next = duty_goal_q;
		end
	end

	// configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pulse_min_q       <= rcpd_pkg::PULSE_MIN_RST;
			pulse_mid_q       <= rcpd_pkg::PULSE_MID_RST;
			pulse_max_q       <= rcpd_pkg::PULSE_MAX_RST;
			dead_band_q       <= rcpd_pkg::DEAD_BAND_RST;
			failsafe_reload_q <= rcpd_pkg::FAILSAFE_RELOAD_RST;
		end else if (cfg_en) begin
			unique case (cfg_index)
				rcpd_pkg::REG_PULSE_MIN:       pulse_min_q       <= cfg_data;
				rcpd_pkg::REG_PULSE_MID:       pulse_mid_q       <= cfg_data;
				rcpd_pkg::REG_PULSE_MAX:       pulse_max_q       <= cfg_data;
				rcpd_pkg::REG_DEAD_BAND:       dead_band_q       <= cfg_data;
				rcpd_pkg::REG_FAILSAFE_RELOAD: failsafe_reload_q <= cfg_data[7:0];
				default: ;
			endcase
		end
	end

	// item latch and pulse width
	always_ff @(posedge clk) begin
		if (in_fire) begin
			func_q  <= in_item.func;
			level_q <= in_item.level;
			stamp_q <= in_item.stamp;
			width_q <= in_item.stamp - rise_stamp_q;
		end
	end

	// sequencer and controller state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q         <= ST_IDLE;
			mode_now_q      <= rcpd_pkg::MODE_UNINIT;
			mode_goal_q     <= rcpd_pkg::MODE_UNINIT;
			duty_goal_q     <= '0;
			duty_now_q      <= '0;
			rise_stamp_q    <= '0;
			failsafe_left_q <= rcpd_pkg::FAILSAFE_RELOAD_RST;
			taken_q         <= 1'b0;
			pend_mode_q     <= rcpd_pkg::MODE_UNINIT;
			out_valid_q     <= 1'b0;
		end else begin
			// output register fills on a finished item, empties on a transfer
			if (state_q == ST_OUT && out_free) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (in_fire) begin
						state_q <= ST_EVAL;
					end
				end
				ST_EVAL: begin
					taken_q <= 1'b0;
					state_q <= ST_OUT;
					if (func_q == rcpd_pkg::FUNC_TICK) begin
						// failsafe countdown, brake on expiry
						if (failsafe_left_q == '0) begin
							if (mode_now_q != rcpd_pkg::MODE_BRAKE) begin
								mode_goal_q <= rcpd_pkg::MODE_BRAKE;
							end
						end else begin
							failsafe_left_q <= failsafe_left_q - 1'b1;
						end
					end else if (level_q) begin
						rise_stamp_q    <= stamp_q;
						failsafe_left_q <= failsafe_reload_q;
					end else if (in_window) begin
						taken_q <= 1'b1;
						if (go_fwd) begin
							pend_mode_q <= rcpd_pkg::MODE_FWD;
							state_q     <= ST_DIV;
						end else if (go_bwd) begin
							pend_mode_q <= rcpd_pkg::MODE_BWD;
							state_q     <= ST_DIV;
						end else begin
							duty_goal_q <= '0;
							mode_goal_q <= rcpd_pkg::MODE_BRAKE;
						end
					end
				end
				ST_DIV: begin
					if (div_done) begin
						duty_goal_q <= div_quo;
						mode_goal_q <= pend_mode_q;
						state_q     <= ST_OUT;
					end
				end
				ST_OUT: begin
					if (out_free) begin
						mode_now_q <= mode_next;
						duty_now_q <= duty_next;
						state_q    <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// result payload
	always_ff @(posedge clk) begin
		if (state_q == ST_OUT && out_free) begin
			out_item_q.drive_mode  <= mode_next;
			out_item_q.duty        <= duty_next;
			out_item_q.wanted_mode <= mode_goal_q;
			out_item_q.pulse_taken <= taken_q;
		end
	end

	assign out_valid = out_valid_q;
	assign out_item  = out_item_q;

endmodule

// ===== dv/tb_rc_pulse_to_hbridge_drive.sv =====
`timescale 1ns / 1ps

module tb_rc_pulse_to_hbridge_drive;

	logic                clk;
	logic                arst_n;
	logic                cfg_en;
	logic [2:0]          cfg_index;
	logic [15:0]         cfg_data;
	logic                in_valid;
	logic                in_stall;
	rcpd_pkg::in_item_t  in_item;
	logic                out_valid;
	logic                out_stall;
	rcpd_pkg::out_item_t out_item;

	rc_pulse_to_hbridge_drive uut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_en    (cfg_en),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.in_item   (in_item),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_item  (out_item)
	);

	// shadow copy of the registers
	logic [15:0] min_r, mid_r, max_r, band_r;
	logic [7:0]  reload_r;

	// shadow copy of the drive state
	logic [1:0]  now_mode, goal_mode;
	logic [7:0]  now_duty, goal_duty, fs_left;
	logic [15:0] rise_at;

	rcpd_pkg::out_item_t drive_due_q[$];
	int          err_count;
	int          sent_count;
	int          result_count;
	bit          tx_idle;
	bit          rx_idle;

	// clock
	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	// overall time limit
	initial begin
		#20_000_000;
		$display("tb_rc_pulse_to_hbridge_drive failed");
		$finish;
	end

	// duty from the distance to neutral, saturating at full scale
	function automatic logic [7:0] duty_from_offset(input int unsigned offset,
			input int unsigned span);
		int unsigned q;
		if (span == 0)
			return 8'd255;
		q = (offset * 256) / span;
		return (q > 255) ? 8'd255 : q[7:0];
	endfunction

	function automatic void reset_shadow();
		min_r     = rcpd_pkg::PULSE_MIN_RST;
		mid_r     = rcpd_pkg::PULSE_MID_RST;
		max_r     = rcpd_pkg::PULSE_MAX_RST;
		band_r    = rcpd_pkg::DEAD_BAND_RST;
		reload_r  = rcpd_pkg::FAILSAFE_RELOAD_RST;
		now_mode  = rcpd_pkg::MODE_UNINIT;
		goal_mode = rcpd_pkg::MODE_UNINIT;
		now_duty  = 8'd0;
		goal_duty = 8'd0;
		fs_left   = 8'd50;
		rise_at   = 16'd0;
	endfunction

	// target update from one item, then one step of the applied drive
	function automatic rcpd_pkg::out_item_t predict_drive(input rcpd_pkg::in_item_t it);
		rcpd_pkg::out_item_t res;
		logic        taken;
		int unsigned w, lo, mid, hi, band;
		taken = 1'b0;
		lo    = 32'(min_r);
		mid   = 32'(mid_r);
		hi    = 32'(max_r);
		band  = 32'(band_r);
		if (it.func == rcpd_pkg::FUNC_TICK) begin
			if (fs_left == 8'd0) begin
				if (now_mode != rcpd_pkg::MODE_BRAKE)
					goal_mode = rcpd_pkg::MODE_BRAKE;
			end else begin
				fs_left = fs_left - 8'd1;
			end
		end else if (it.level) begin
			rise_at = it.stamp;
			fs_left = reload_r;
		end else begin
			w = 32'(16'(it.stamp - rise_at));
			if (w > lo && w < hi) begin
				taken = 1'b1;
				if (w > mid + band) begin
					goal_duty = duty_from_offset(w - mid, (hi > mid) ? hi - mid : 0);
					goal_mode = rcpd_pkg::MODE_FWD;
				end else if (mid >= band && w < mid - band) begin
					goal_duty = duty_from_offset(mid - w, (mid > lo) ? mid - lo : 0);
					goal_mode = rcpd_pkg::MODE_BWD;
				end else begin
					goal_duty = 8'd0;
					goal_mode = rcpd_pkg::MODE_BRAKE;
				end
			end
		end
		// brake before any change of direction
		if (now_mode != goal_mode) begin
			if ((goal_mode == rcpd_pkg::MODE_FWD || goal_mode == rcpd_pkg::MODE_BWD)
				&& now_mode == rcpd_pkg::MODE_BRAKE) begin
				now_duty = 8'd0;
				now_mode = goal_mode;
			end else begin
				now_mode = rcpd_pkg::MODE_BRAKE;
			end
		end else begin
			now_duty = goal_duty;
		end
		res.drive_mode  = now_mode;
		res.duty        = now_duty;
		res.wanted_mode = goal_mode;
		res.pulse_taken = taken;
		return res;
	endfunction

	task automatic report_mismatch(input string what, input int got, input int want);
		$display("mismatch on result %0d: %s is %0d, expected %0d", result_count, what, got, want);
		err_count++;
	endtask

	// one input transfer, with an optional gap before it
	task automatic send_item(input rcpd_pkg::in_item_t it);
		if (tx_idle && $urandom_range(0, 3) == 0) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 10)) @(posedge clk);
		end
		in_valid <= 1'b1;
		in_item  <= it;
		do @(posedge clk); while (in_stall !== 1'b0);
		drive_due_q.push_back(predict_drive(it));
		sent_count++;
	endtask

	task automatic send_edge(input logic lvl, input logic [15:0] stamp);
		rcpd_pkg::in_item_t it;
		it.func  = rcpd_pkg::FUNC_EDGE;
		it.level = lvl;
		it.stamp = stamp;
		send_item(it);
	endtask

	task automatic send_tick(input logic lvl, input logic [15:0] stamp);
		rcpd_pkg::in_item_t it;
		it.func  = rcpd_pkg::FUNC_TICK;
		it.level = lvl;
		it.stamp = stamp;
		send_item(it);
	endtask

	// hold the input and let every outstanding result come out
	task automatic wait_drained();
		in_valid <= 1'b0;
		do @(posedge clk); while (drive_due_q.size() != 0);
	endtask

	task automatic write_reg(input logic [2:0] idx, input logic [15:0] data);
		cfg_en    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= data;
		@(posedge clk);
		case (idx)
			rcpd_pkg::REG_PULSE_MIN:       min_r    = data;
			rcpd_pkg::REG_PULSE_MID:       mid_r    = data;
			rcpd_pkg::REG_PULSE_MAX:       max_r    = data;
			rcpd_pkg::REG_DEAD_BAND:       band_r   = data;
			rcpd_pkg::REG_FAILSAFE_RELOAD: reload_r = data[7:0];
			default: ;
		endcase
	endtask

	task automatic set_regs(input logic [15:0] lo, input logic [15:0] mid,
			input logic [15:0] hi, input logic [15:0] band, input logic [7:0] reload);
		logic [7:0] junk;
		junk = 8'($urandom);
		wait_drained();
		write_reg(rcpd_pkg::REG_PULSE_MIN, lo);
		write_reg(rcpd_pkg::REG_PULSE_MID, mid);
		write_reg(rcpd_pkg::REG_PULSE_MAX, hi);
		write_reg(rcpd_pkg::REG_DEAD_BAND, band);
		// upper bits of the reload write are dont-care
		write_reg(rcpd_pkg::REG_FAILSAFE_RELOAD, {junk, reload});
		cfg_en <= 1'b0;
		@(posedge clk);
	endtask

	// pulse width biased towards the window and its edges
	function automatic logic [15:0] pick_width();
		case ($urandom_range(0, 9))
			0: return 16'($urandom);
			1: return 16'(mid_r + band_r + $urandom_range(0, 2) - 1);
			2: return 16'(mid_r - band_r + $urandom_range(0, 2) - 1);
			3: return 16'(min_r + $urandom_range(0, 2));
			4: return 16'(max_r - $urandom_range(0, 2));
			default: begin
				if (max_r > min_r)
					return 16'($urandom_range(min_r, max_r));
				return 16'($urandom);
			end
		endcase
	endfunction

	// mostly well formed pulses, some noise and broken pulses
	task automatic pulse_sequence();
		logic [15:0]        s;
		rcpd_pkg::in_item_t noise;
		int                 kind;
		s     = 16'($urandom);
		noise = 18'($urandom);
		kind  = $urandom_range(0, 19);
		if (kind < 15) begin
			send_edge(1'b1, s);
			repeat ($urandom_range(0, 2)) send_tick(1'($urandom), 16'($urandom));
			send_edge(1'b0, s + pick_width());
		end else if (kind < 17) begin
			send_item(noise);
		end else if (kind == 17) begin
			send_edge(1'b0, rise_at + pick_width());
		end else if (kind == 18) begin
			send_edge(1'b1, s);
			send_edge(1'b1, s + 16'($urandom_range(0, 300)));
			send_edge(1'b0, s + pick_width());
		end else begin
			repeat ($urandom_range(1, int'(reload_r) + 2))
				send_tick(1'($urandom), 16'($urandom));
		end
	endtask

	task automatic test_directed_edges();
		// falling edge with no rising edge measures from zero
		send_edge(1'b0, 16'd400);
		// tick fields are ignored
		send_tick(1'b1, 16'hFFFF);
		send_tick(1'b0, 16'h0000);
		// width wraps through zero, lands in the brake zone
		send_edge(1'b1, 16'hFFF0);
		send_edge(1'b0, 16'h0160);
		// just above the lower bound, near full backward
		send_edge(1'b1, 16'd100);
		send_edge(1'b0, 16'd351);
		send_tick(1'b0, 16'h5555);
		send_tick(1'b1, 16'hAAAA);
		// window bounds are exclusive
		send_edge(1'b0, 16'd350);
		send_edge(1'b0, 16'd600);
		send_edge(1'b0, 16'd599);
		send_tick(1'b0, 16'd0);
		send_tick(1'b0, 16'd0);
		// dead band limits
		send_edge(1'b0, 16'd464);
		send_edge(1'b0, 16'd465);
		send_edge(1'b0, 16'd485);
		send_edge(1'b0, 16'd486);
		// zero width and a wrapped valid width
		send_edge(1'b1, 16'h0000);
		send_edge(1'b0, 16'h0000);
		send_edge(1'b1, 16'hFFFF);
		send_edge(1'b0, 16'h0180);
		send_tick(1'b1, 16'h0F0F);
	endtask

	task automatic test_failsafe();
		// reload of zero: the first tick after a rising edge expires
		set_regs(rcpd_pkg::PULSE_MIN_RST, rcpd_pkg::PULSE_MID_RST, rcpd_pkg::PULSE_MAX_RST,
			rcpd_pkg::DEAD_BAND_RST, 8'd0);
		send_edge(1'b1, 16'd1000);
		send_tick(1'b0, 16'd0);
		send_edge(1'b0, 16'd1450);
		repeat (4) send_tick(1'($urandom), 16'($urandom));
		send_edge(1'b1, 16'd2000);
		send_edge(1'b0, 16'd2300);
		repeat (3) send_tick(1'($urandom), 16'($urandom));
		// one tick of grace
		set_regs(rcpd_pkg::PULSE_MIN_RST, rcpd_pkg::PULSE_MID_RST, rcpd_pkg::PULSE_MAX_RST,
			rcpd_pkg::DEAD_BAND_RST, 8'd1);
		send_edge(1'b1, 16'd3000);
		send_edge(1'b0, 16'd3440);
		repeat (4) send_tick(1'($urandom), 16'($urandom));
		// longest count
		set_regs(rcpd_pkg::PULSE_MIN_RST, rcpd_pkg::PULSE_MID_RST, rcpd_pkg::PULSE_MAX_RST,
			rcpd_pkg::DEAD_BAND_RST, 8'd255);
		send_edge(1'b1, 16'd4000);
		send_edge(1'b0, 16'd4480);
		repeat (258) send_tick(1'($urandom), 16'($urandom));
		// default count
		set_regs(rcpd_pkg::PULSE_MIN_RST, rcpd_pkg::PULSE_MID_RST, rcpd_pkg::PULSE_MAX_RST,
			rcpd_pkg::DEAD_BAND_RST, rcpd_pkg::FAILSAFE_RELOAD_RST);
		send_edge(1'b1, 16'd5000);
		send_edge(1'b0, 16'd5270);
		repeat (52) send_tick(1'($urandom), 16'($urandom));
	endtask

	task automatic test_random_traffic();
		int          goal;
		logic [15:0] lo, mid, hi;
		for (int ph = 0; ph < 9; ph++) begin
			lo  = 16'($urandom_range(0, 2000));
			mid = lo + 16'($urandom_range(1, 1000));
			hi  = mid + 16'($urandom_range(1, 1000));
			case (ph)
				0: set_regs(rcpd_pkg::PULSE_MIN_RST, rcpd_pkg::PULSE_MID_RST,
					rcpd_pkg::PULSE_MAX_RST, rcpd_pkg::DEAD_BAND_RST,
					rcpd_pkg::FAILSAFE_RELOAD_RST);
				1: set_regs(16'd0, 16'd32768, 16'hFFFF, 16'd0, 8'd255);
				// neutral below the window and a band wider than neutral
				2: set_regs(16'd300, 16'd200, 16'd600, 16'd400, 8'd0);
				3: set_regs(16'd0, 16'hFFFF, 16'hFFFF, 16'hFFFF, 8'd3);
				// empty window
				6: set_regs(16'hFFFF, 16'd0, 16'd0, 16'd0, 8'd1);
				default: set_regs(lo, mid, hi, 16'($urandom_range(0, 100)),
					8'($urandom_range(0, 20)));
			endcase
			// stretches without idling in the middle and at the end
			tx_idle = (ph != 4 && ph != 8);
			rx_idle = (ph != 4 && ph != 8);
			goal = sent_count + ((ph == 6) ? 40 : 110);
			while (sent_count < goal) begin
				pulse_sequence();
				if ($urandom_range(0, 39) == 0)
					wait_drained();
			end
		end
	endtask

	// receiver stall in random bursts
	initial begin
		out_stall <= 1'b0;
		forever begin
			@(posedge clk);
			if (rx_idle && $urandom_range(0, 4) == 0) begin
				out_stall <= 1'b1;
				repeat ($urandom_range(1, 10)) @(posedge clk);
				out_stall <= 1'b0;
			end
		end
	end

	// compare each result transfer with the oldest expectation
	always @(posedge clk) begin
		rcpd_pkg::out_item_t want;
		if (arst_n === 1'b1 && out_valid === 1'b1 && out_stall === 1'b0) begin
			if (drive_due_q.size() == 0) begin
				report_mismatch("unexpected result", int'(out_item), 0);
			end else begin
				want = drive_due_q.pop_front();
				if (out_item.drive_mode !== want.drive_mode)
					report_mismatch("drive_mode", int'(out_item.drive_mode),
						int'(want.drive_mode));
				if (out_item.duty !== want.duty)
					report_mismatch("duty", int'(out_item.duty), int'(want.duty));
				if (out_item.wanted_mode !== want.wanted_mode)
					report_mismatch("wanted_mode", int'(out_item.wanted_mode),
						int'(want.wanted_mode));
				if (out_item.pulse_taken !== want.pulse_taken)
					report_mismatch("pulse_taken", int'(out_item.pulse_taken),
						int'(want.pulse_taken));
			end
			result_count++;
		end
	end

	// test sequence
	initial begin
		err_count    = 0;
		sent_count   = 0;
		result_count = 0;
		tx_idle      = 1'b1;
		rx_idle      = 1'b1;
		reset_shadow();
		arst_n    <= 1'b0;
		cfg_en    <= 1'b0;
		cfg_index <= rcpd_pkg::REG_PULSE_MIN;
		cfg_data  <= 16'd0;
		in_valid  <= 1'b0;
		in_item   <= '0;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed_edges();
		test_failsafe();
		test_random_traffic();
		wait_drained();
		repeat (20) @(posedge clk);
		if (drive_due_q.size() != 0)
			report_mismatch("results still outstanding", 0, drive_due_q.size());
		if (err_count == 0)
			$display("tb_rc_pulse_to_hbridge_drive passed");
		else
			$display("tb_rc_pulse_to_hbridge_drive failed");
		$finish;
	end

endmodule
